// ===== sv/seir_pkg.sv =====
// Shared types and constants for the SEIR forward-Euler step block.
`default_nettype none

package seir_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MU    = 3'd0,
    REG_ALPHA = 3'd1,
    REG_BETA  = 3'd2,
    REG_GAMMA = 3'd3,
    REG_DT    = 3'd4,
    REG_NPOP  = 3'd5
  } cfg_idx_e;

  // Command codes on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Register reset values
  localparam logic [31:0] MU_RST    = 32'd419430;
  localparam logic [31:0] ALPHA_RST = 32'd3355443;
  localparam logic [31:0] BETA_RST  = 32'd16777;
  localparam logic [31:0] GAMMA_RST = 32'd5872026;
  localparam logic [31:0] DT_RST    = 32'd167772;
  localparam logic [31:0] NPOP_RST  = 32'd65536000;

  // Compartment reset values
  localparam logic [31:0] SUS_RST = 32'd62259200;
  localparam logic [31:0] EXP_RST = 32'd2621440;
  localparam logic [31:0] INF_RST = 32'd655360;
  localparam logic [31:0] REC_RST = 32'd0;

  // Shared multiplier geometry
  localparam int unsigned MUL_AW = 33;
  localparam int unsigned MUL_BW = 32;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // Product magnitude cap is 2^PROD_W - 1; rate accumulators are DW bits signed
  localparam int unsigned PROD_W = 56;
  localparam int unsigned DW     = PROD_W + 2;

  // Micro-op sequence, one multiply each
  localparam int unsigned NUM_OPS = 17;
  localparam int unsigned CNT_W   = $clog2(NUM_OPS + 1);

  typedef enum logic [CNT_W-1:0] {
    OP_SI     = 5'd0,
    OP_INF_LO = 5'd1,
    OP_INF_HI = 5'd2,
    OP_BIRTH  = 5'd3,
    OP_EOUT   = 5'd4,
    OP_E2I    = 5'd5,
    OP_IOUT   = 5'd6,
    OP_I2R    = 5'd7,
    OP_ROUT   = 5'd8,
    OP_S_LO   = 5'd9,
    OP_S_HI   = 5'd10,
    OP_E_LO   = 5'd11,
    OP_E_HI   = 5'd12,
    OP_I_LO   = 5'd13,
    OP_I_HI   = 5'd14,
    OP_R_LO   = 5'd15,
    OP_R_HI   = 5'd16
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic idle;
    logic iss_vld;
    op_e  iss_op;
    logic con_vld;
    op_e  con_op;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== sv/seir_mul.sv =====
// Shared registered multiplier for the SEIR step datapath.
`default_nettype none

module seir_mul (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [seir_pkg::MUL_AW-1:0] a_i,
  input  wire logic [seir_pkg::MUL_BW-1:0] b_i,
  output logic      [seir_pkg::MUL_PW-1:0] p_o
);
  import seir_pkg::*;

  logic [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/seir_ctrl.sv =====
// Sequencer for the SEIR step: walks the multiply micro-ops and hands off results.
`default_nettype none

module seir_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire logic            step_i,
  input  wire logic            out_free_i,
  output seir_pkg::ctrl_t      ctrl_o
);
  import seir_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             con_vld_q;
  op_e              con_op_q;
  logic             iss_vld;

  assign iss_vld = (state_q == ST_RUN) && (cnt_q != CNT_W'(NUM_OPS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      con_vld_q <= 1'b0;
      con_op_q  <= OP_SI;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      con_vld_q <= iss_vld;
      con_op_q  <= op_e'(cnt_q);
    end
  end

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    ctrl_o.idle     = (state_q == ST_IDLE);
    ctrl_o.iss_vld  = iss_vld;
    ctrl_o.iss_op   = op_e'(cnt_q);
    ctrl_o.con_vld  = con_vld_q;
    ctrl_o.con_op   = con_op_q;
    ctrl_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_i) begin
          cnt_d   = '0;
          state_d = step_i ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        if (cnt_q == CNT_W'(NUM_OPS)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> state_q == ST_IDLE)
    else $error("beat accepted while sequencer busy");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == CNT_W'(NUM_OPS)) |=> (state_q == ST_DONE && !con_vld_q))
    else $error("sequence did not close cleanly");

  a_con_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    con_vld_q |-> state_q == ST_RUN)
    else $error("product consumed outside run");

endmodule

`default_nettype wire

// ===== sv/seir_euler_step.sv =====
// Top level of the SEIR forward-Euler step block: registers, datapath and stream ports.
//
// Input beats on s_axis: tuser selects load (0) or step (1); a load replaces the four
// Q16.16 compartments from tdata, a step advances them by one Euler step using the
// rate registers. Every input beat yields exactly one output beat on m_axis carrying
// the four compartments, the step count since the last load and a clamp flag.
// Rate registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them
// only while idle, as the block itself does not enforce this. A step issues 17 products one
// per cycle through a single registered 33x32 multiplier, then drains the last product and
// loads the output register; a load skips the products and only loads the output register.
// s_axis_tready is high only while the block is idle; one item is in flight at a time.
// If m_axis_tready is low when a result is ready, the block holds it and stays busy
// until the waiting output beat is taken.
// Reset restores the rate registers, compartments S=950, E=40, I=10, R=0 and a zero
// step count, and leaves m_axis empty.
`default_nettype none

module seir_euler_step #(
  parameter int unsigned POP_FRAC_BITS  = 16,
  parameter int unsigned RATE_FRAC_BITS = 24
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [seir_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [31:0]                      cfg_data_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [127:0]                     s_axis_tdata,  // susceptible_in, exposed_in,
                                                               // infectious_in, recovered_in
  input  wire logic                             s_axis_tuser,  // cmd
  // output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [143:0]                          m_axis_tdata,  // susceptible_out, exposed_out,
                                                               // infectious_out, recovered_out,
                                                               // step_index
  output logic                                  m_axis_tuser   // clamped
);
  import seir_pkg::*;

  localparam int unsigned SI_W    = 64 - POP_FRAC_BITS;
  localparam int unsigned SI_HI_W = SI_W - 32;
  localparam int unsigned WIDE_W  = MUL_PW + 32;

  // configuration
  logic [31:0] mu_q, alpha_q, beta_q, gamma_q, dt_q, npop_q;

  // compartments and status
  logic [31:0] sus_q, exp_q, inf_q, rec_q;
  logic [15:0] step_q;
  logic        clamp_q;

  // per-step working registers
  logic signed [DW-1:0]     ds_q, de_q, di_q, dr_q;
  logic [MUL_PW-1:0]        lo_q;
  logic [SI_HI_W-1:0]       si_hi_q;
  logic [PROD_W:0]          mag_q;
  logic [31:0]              nd_mag_q;
  logic                     nd_neg_q;
  logic [32:0]              mua_q, mug_q;

  // output register
  logic         m_valid_q;
  logic [143:0] m_data_q;
  logic         m_user_q;

  ctrl_t             ctrl;
  logic              in_acc;
  logic              out_free;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] prod;

  logic [MUL_PW-1:0]    si_full;
  logic signed [DW-1:0] term;
  logic [WIDE_W-1:0]    comb_w, comb_s;
  logic [PROD_W-1:0]    comb_mag;
  logic signed [DW-1:0] comb_t;
  logic signed [DW-1:0] d_sel, d_abs;
  logic [32:0]          nd_diff, nd_abs;
  logic [31:0]          set_old;
  logic                 set_neg;
  logic [32:0]          set_res;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = ctrl.idle;
  assign out_free      = !m_valid_q || m_axis_tready;

  seir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .step_i     (s_axis_tuser == CMD_STEP),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  seir_mul u_mul (
    .clk_i (clk_i),
    .en_i  (ctrl.iss_vld),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // clamp a step result into the unsigned 32-bit range; top bit flags a clamp
  function automatic logic [32:0] settle(input logic [31:0] old, input logic neg,
                                         input logic [PROD_W-1:0] mag);
    logic signed [DW-1:0] m;
    logic signed [DW-1:0] v;
    m = signed'({2'b00, mag});
    v = signed'({{(DW-32){1'b0}}, old}) + (neg ? -m : m);
    if (v[DW-1]) begin
      settle = {1'b1, 32'd0};
    end else if (|v[DW-2:32]) begin
      settle = {1'b1, 32'hFFFF_FFFF};
    end else begin
      settle = {1'b0, v[31:0]};
    end
  endfunction

  // product taps
  always_comb begin
    si_full  = MUL_PW'(prod >> POP_FRAC_BITS);
    term     = signed'(DW'(prod >> RATE_FRAC_BITS));
    comb_w   = {prod, 32'd0} + {32'd0, lo_q};
    comb_s   = comb_w >> RATE_FRAC_BITS;
    comb_mag = (|comb_s[WIDE_W-1:PROD_W]) ? '1 : comb_s[PROD_W-1:0];
    comb_t   = signed'({2'b00, comb_mag});
    nd_diff  = {1'b0, npop_q} - {1'b0, sus_q};
    nd_abs   = nd_diff[32] ? (33'd0 - nd_diff) : nd_diff;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.iss_op)
      OP_SI:     begin mul_a = {1'b0, sus_q};                 mul_b = inf_q;   end
      OP_INF_LO: begin mul_a = {1'b0, si_full[31:0]};         mul_b = beta_q;  end
      OP_INF_HI: begin mul_a = MUL_AW'(si_hi_q);              mul_b = beta_q;  end
      OP_BIRTH:  begin mul_a = {1'b0, nd_mag_q};              mul_b = mu_q;    end
      OP_EOUT:   begin mul_a = mua_q;                         mul_b = exp_q;   end
      OP_E2I:    begin mul_a = {1'b0, alpha_q};               mul_b = exp_q;   end
      OP_IOUT:   begin mul_a = mug_q;                         mul_b = inf_q;   end
      OP_I2R:    begin mul_a = {1'b0, gamma_q};               mul_b = inf_q;   end
      OP_ROUT:   begin mul_a = {1'b0, mu_q};                  mul_b = rec_q;   end
      OP_S_LO, OP_E_LO, OP_I_LO, OP_R_LO: begin
        mul_a = {1'b0, mag_q[31:0]};
        mul_b = dt_q;
      end
      OP_S_HI, OP_E_HI, OP_I_HI, OP_R_HI: begin
        mul_a = MUL_AW'(mag_q[PROD_W:32]);
        mul_b = dt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // magnitude of the next derivative to integrate, registered in mag_q before its products issue
  always_comb begin
    case (ctrl.iss_op)
      OP_ROUT: d_sel = ds_q;
      OP_S_HI: d_sel = de_q;
      OP_E_HI: d_sel = di_q;
      default: d_sel = dr_q;
    endcase
    d_abs = d_sel[DW-1] ? -d_sel : d_sel;
  end

  // settle operands
  always_comb begin
    case (ctrl.con_op)
      OP_S_HI: begin set_old = sus_q; set_neg = ds_q[DW-1]; end
      OP_E_HI: begin set_old = exp_q; set_neg = de_q[DW-1]; end
      OP_I_HI: begin set_old = inf_q; set_neg = di_q[DW-1]; end
      default: begin set_old = rec_q; set_neg = dr_q[DW-1]; end
    endcase
    set_res = settle(set_old, set_neg, comb_mag);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q    <= MU_RST;
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      gamma_q <= GAMMA_RST;
      dt_q    <= DT_RST;
      npop_q  <= NPOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MU:    mu_q    <= cfg_data_i;
        REG_ALPHA: alpha_q <= cfg_data_i;
        REG_BETA:  beta_q  <= cfg_data_i;
        REG_GAMMA: gamma_q <= cfg_data_i;
        REG_DT:    dt_q    <= cfg_data_i;
        REG_NPOP:  npop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // compartments, step count and clamp flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sus_q   <= SUS_RST;
      exp_q   <= EXP_RST;
      inf_q   <= INF_RST;
      rec_q   <= REC_RST;
      step_q  <= '0;
      clamp_q <= 1'b0;
    end else if (in_acc) begin
      clamp_q <= 1'b0;
      if (s_axis_tuser == CMD_LOAD) begin
        sus_q  <= s_axis_tdata[31:0];
        exp_q  <= s_axis_tdata[63:32];
        inf_q  <= s_axis_tdata[95:64];
        rec_q  <= s_axis_tdata[127:96];
        step_q <= '0;
      end else begin
        step_q <= step_q + 16'd1;
      end
    end else if (ctrl.con_vld) begin
      case (ctrl.con_op)
        OP_S_HI: begin sus_q <= set_res[31:0]; clamp_q <= clamp_q | set_res[32]; end
        OP_E_HI: begin exp_q <= set_res[31:0]; clamp_q <= clamp_q | set_res[32]; end
        OP_I_HI: begin inf_q <= set_res[31:0]; clamp_q <= clamp_q | set_res[32]; end
        OP_R_HI: begin rec_q <= set_res[31:0]; clamp_q <= clamp_q | set_res[32]; end
        default: ;
      endcase
    end
  end

  // derivative accumulators and partial products
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ds_q     <= '0;
      de_q     <= '0;
      di_q     <= '0;
      dr_q     <= '0;
      nd_neg_q <= nd_diff[32];
      nd_mag_q <= nd_abs[31:0];
      mua_q    <= {1'b0, mu_q} + {1'b0, alpha_q};
      mug_q    <= {1'b0, mu_q} + {1'b0, gamma_q};
    end else if (ctrl.con_vld) begin
      case (ctrl.con_op)
        OP_SI:     si_hi_q <= si_full[SI_W-1:32];
        OP_INF_LO: lo_q    <= prod;
        OP_INF_HI: begin
          ds_q <= ds_q - comb_t;
          de_q <= de_q + comb_t;
        end
        OP_BIRTH:  ds_q <= nd_neg_q ? (ds_q - term) : (ds_q + term);
        OP_EOUT:   de_q <= de_q - term;
        OP_E2I:    di_q <= di_q + term;
        OP_IOUT:   di_q <= di_q - term;
        OP_I2R:    dr_q <= dr_q + term;
        OP_ROUT:   dr_q <= dr_q - term;
        OP_S_LO, OP_E_LO, OP_I_LO, OP_R_LO: lo_q <= prod;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.iss_vld) begin
      case (ctrl.iss_op)
        OP_ROUT, OP_S_HI, OP_E_HI, OP_I_HI: mag_q <= d_abs[PROD_W:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      m_data_q <= {step_q, rec_q, inf_q, exp_q, sus_q};
      m_user_q <= clamp_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready stayed high after an accepted beat");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> out_free)
    else $error("output overwritten while a beat waits");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("waiting output beat changed or dropped");

endmodule

`default_nettype wire

// ===== test/tb_seir_euler_step.sv =====
// Self-checking testbench for seir_euler_step: random load/step beats against a fixed-point predictor.
module tb_seir_euler_step;
  timeunit 1ns;
  timeprecision 1ps;
  import seir_pkg::*;

  localparam int unsigned POP_Q       = 16;
  localparam int unsigned RATE_Q      = 24;
  localparam int unsigned CAP_BITS    = 56;
  localparam logic [63:0] MAG_CAP     = (64'd1 << CAP_BITS) - 64'd1;
  localparam longint      POP_MAX     = 64'sd4294967295;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned LONG_STALL  = 400;
  localparam int unsigned REPORT_CAP  = 50;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(REG_NPOP + 1);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(REG_NPOP + 2);

  typedef enum {CFG_DEFAULT, CFG_ZERO, CFG_FULL, CFG_PLAUSIBLE, CFG_WILD, CFG_MIXED} cfg_mix_e;

  typedef struct packed {
    logic             cmd;
    logic [3:0][31:0] pop;   // S, E, I, R from index 0 up
  } seir_item_t;

  typedef struct packed {
    logic             clamped;
    logic [15:0]      count;
    logic [3:0][31:0] pop;
  } census_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [31:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [127:0]         s_axis_tdata  = '0;  // susceptible_in, exposed_in, infectious_in,
                                             // recovered_in
  logic                 s_axis_tuser  = CMD_LOAD;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [143:0]         m_axis_tdata;  // susceptible_out, exposed_out, infectious_out,
                                       // recovered_out, step_index
  logic                 m_axis_tuser;  // clamped

  // predictor copy of registers and compartments
  logic [31:0]      reg_mu    = MU_RST;
  logic [31:0]      reg_alpha = ALPHA_RST;
  logic [31:0]      reg_beta  = BETA_RST;
  logic [31:0]      reg_gamma = GAMMA_RST;
  logic [31:0]      reg_dt    = DT_RST;
  logic [31:0]      reg_npop  = NPOP_RST;
  logic [3:0][31:0] pop_now   = {REC_RST, INF_RST, EXP_RST, SUS_RST};
  logic [15:0]      step_now  = '0;

  seir_item_t  pending [$];
  census_t     results_due [$];
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served  = 0;
  int unsigned stall_left     = 0;
  string       comp_name [4]  = '{"susceptible", "exposed", "infectious", "recovered"};

  seir_euler_step #(
    .POP_FRAC_BITS (POP_Q),
    .RATE_FRAC_BITS(RATE_Q)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // exact product, shifted, magnitude capped
  function automatic logic [63:0] scale_mag(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = ({64'b0, a} * {64'b0, b}) >> sh;
    return (p > {64'b0, MAG_CAP}) ? MAG_CAP : p[63:0];
  endfunction

  // sign-magnitude: truncates toward zero
  function automatic longint scale_signed(longint a, logic [63:0] b, int unsigned sh);
    logic [63:0] m;
    m = (a < 0) ? -a : a;
    m = scale_mag(m, b, sh);
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] settle(logic [31:0] old, longint d, inout logic flag);
    longint v;
    v = longint'({32'b0, old}) + scale_signed(d, {32'b0, reg_dt}, RATE_Q);
    if (v < 0) begin
      flag = 1'b1;
      return '0;
    end
    if (v > POP_MAX) begin
      flag = 1'b1;
      return '1;
    end
    return v[31:0];
  endfunction

  function automatic census_t advance_census(seir_item_t it);
    census_t          c;
    longint           si, infl, births, e_out, e_to_i, i_out, i_to_r, r_out;
    logic             flag;
    logic [3:0][31:0] nxt;
    flag = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      pop_now  = it.pop;
      step_now = '0;
    end else begin
      si     = longint'(scale_mag({32'b0, pop_now[0]}, {32'b0, pop_now[2]}, POP_Q));
      infl   = scale_signed(si, {32'b0, reg_beta}, RATE_Q);
      births = scale_signed(longint'({32'b0, reg_npop}) - longint'({32'b0, pop_now[0]}),
                            {32'b0, reg_mu}, RATE_Q);
      e_out  = longint'(scale_mag({32'b0, reg_mu} + {32'b0, reg_alpha},
                                  {32'b0, pop_now[1]}, RATE_Q));
      e_to_i = longint'(scale_mag({32'b0, reg_alpha}, {32'b0, pop_now[1]}, RATE_Q));
      i_out  = longint'(scale_mag({32'b0, reg_mu} + {32'b0, reg_gamma},
                                  {32'b0, pop_now[2]}, RATE_Q));
      i_to_r = longint'(scale_mag({32'b0, reg_gamma}, {32'b0, pop_now[2]}, RATE_Q));
      r_out  = longint'(scale_mag({32'b0, reg_mu}, {32'b0, pop_now[3]}, RATE_Q));
      nxt[0] = settle(pop_now[0], births - infl, flag);
      nxt[1] = settle(pop_now[1], infl - e_out, flag);
      nxt[2] = settle(pop_now[2], e_to_i - i_out, flag);
      nxt[3] = settle(pop_now[3], i_to_r - r_out, flag);
      pop_now  = nxt;
      step_now = step_now + 16'd1;
    end
    c.pop     = pop_now;
    c.count   = step_now;
    c.clamped = flag;
    return c;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatches < REPORT_CAP)
      $display("%0t ns: %s mismatch, got %h expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_MU:    reg_mu    = val;
      REG_ALPHA: reg_alpha = val;
      REG_BETA:  reg_beta  = val;
      REG_GAMMA: reg_gamma = val;
      REG_DT:    reg_dt    = val;
      REG_NPOP:  reg_npop  = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_mix_e mix);
    logic [31:0] val  [6];
    logic [31:0] dflt [6];
    dflt = '{MU_RST, ALPHA_RST, BETA_RST, GAMMA_RST, DT_RST, NPOP_RST};
    for (int r = 0; r < 6; r++) begin
      case (mix)
        CFG_DEFAULT: val[r] = dflt[r];
        CFG_ZERO:    val[r] = '0;
        CFG_FULL:    val[r] = '1;
        CFG_PLAUSIBLE: begin
          if (r == REG_DT)        val[r] = $urandom_range(0, 1 << 22);
          else if (r == REG_NPOP) val[r] = $urandom_range(0, 1 << 30);
          else                    val[r] = $urandom_range(0, 1 << 24);
        end
        CFG_WILD:    val[r] = $urandom;
        default: begin
          case ($urandom_range(3))
            0:       val[r] = '0;
            1:       val[r] = '1;
            2:       val[r] = $urandom;
            default: val[r] = $urandom_range(0, 1 << 24);
          endcase
        end
      endcase
    end
    cfg_write(IDX_SPARE_LO, $urandom);
    for (int r = 0; r < 6; r++)
      cfg_write(cfg_idx_e'(r), val[r]);
    cfg_write(IDX_SPARE_HI, $urandom);
  endtask

  function automatic logic [3:0][31:0] draw_census();
    logic [3:0][31:0] p;
    int unsigned      mix;
    mix = $urandom_range(9);
    for (int k = 0; k < 4; k++) begin
      if (mix < 5)      p[k] = $urandom_range(0, 32'h0400_0000);
      else if (mix < 6) p[k] = $urandom_range(0, 255);
      else if (mix < 8) p[k] = $urandom;
      else begin
        case ($urandom_range(3))
          0:       p[k] = '0;
          1:       p[k] = '1;
          2:       p[k] = 32'd1;
          default: p[k] = $urandom;
        endcase
      end
    end
    return p;
  endfunction

  task automatic stash_item(seir_item_t it);
    pending = {pending, it};
  endtask

  task automatic queue_load(logic [3:0][31:0] p);
    stash_item(seir_item_t'{cmd: CMD_LOAD, pop: p});
  endtask

  // step beats carry random payload that must be ignored
  task automatic queue_steps(int unsigned n);
    repeat (n)
      stash_item(seir_item_t'{cmd: CMD_STEP, pop: {$urandom, $urandom, $urandom, $urandom}});
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (pending.size() != 0 || s_axis_tvalid || results_due.size() != 0);
  endtask

  task automatic run_block(int unsigned quota, bit with_stall);
    int unsigned made;
    int unsigned n;
    made = 0;
    while (made < quota) begin
      if ($urandom_range(99) < 85) begin
        queue_load(draw_census());
        n = $urandom_range(1, 30);
        queue_steps(n);
        made += n + 1;
      end else if ($urandom_range(1) == 1) begin
        queue_steps(1);
        made++;
      end else begin
        queue_load(draw_census());
        made++;
      end
    end
    if (with_stall) begin
      @(posedge clk_i);
      stall_requests <= stall_requests + 1;
    end
    drain();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed
    seir_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CMD_LOAD;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        results_due = {results_due,
                       advance_census(seir_item_t'{cmd: s_axis_tuser, pop: s_axis_tdata})};
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.pop;
          s_axis_tuser  <= nxt.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      stalls_served <= 0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_served != stall_requests) begin
      stalls_served <= stalls_served + 1;
      stall_left    <= LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check
    census_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        flag_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
      end else begin
        want = results_due.pop_front();
        for (int k = 0; k < 4; k++)
          if (m_axis_tdata[32*k +: 32] !== want.pop[k])
            flag_mismatch(comp_name[k], m_axis_tdata[32*k +: 32], want.pop[k]);
        if (m_axis_tdata[143:128] !== want.count)
          flag_mismatch("step_index", {16'b0, m_axis_tdata[143:128]}, {16'b0, want.count});
        if (m_axis_tuser !== want.clamped)
          flag_mismatch("clamped", {31'b0, m_axis_tuser}, {31'b0, want.clamped});
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned idx;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, zero and full compartments, bit patterns
    queue_steps(3);
    queue_load('0);
    queue_steps(2);
    queue_load('1);
    queue_steps(2);
    queue_load({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    queue_steps(1);
    drain();
    // all-ones rates: product caps, clamps at both ends
    apply_config(CFG_FULL);
    queue_load('1);
    queue_steps(1);
    queue_load({32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd0});
    queue_steps(1);
    drain();
    apply_config(CFG_ZERO);
    queue_load({32'd0, INF_RST, EXP_RST, SUS_RST});
    queue_steps(2);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= (ph == 0) ? 19 : (ph == 1) ? 80 : 0;
      recv_idle_pct <= (ph == 0) ? 80 : (ph == 1) ? 19 : 0;
      for (int b = 0; b < 4; b++) begin
        idx = ph * 4 + b;
        apply_config(idx < 6 ? cfg_mix_e'(idx) : cfg_mix_e'($urandom_range(0, 5)));
        run_block(145, b == 0);
      end
    end

    // run from the default outbreak
    apply_config(CFG_DEFAULT);
    queue_load({REC_RST, INF_RST, EXP_RST, SUS_RST});
    queue_steps(60);
    drain();

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && results_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
